### rtl/esd_pkg.sv
package esd_pkg;

    localparam logic [15:0] U_TAB   = 16'h0009;
    localparam logic [15:0] U_LF    = 16'h000A;
    localparam logic [15:0] U_CR    = 16'h000D;
    localparam logic [15:0] U_BSL   = 16'h005C;
    localparam logic [15:0] U_LOW_T = 16'h0074;
    localparam logic [15:0] U_LOW_R = 16'h0072;
    localparam logic [15:0] U_LOW_N = 16'h006E;
    localparam logic [15:0] U_LOW_X = 16'h0078;
    localparam logic [15:0] U_ZERO  = 16'h0000;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int N_SLOTS = 8;
    localparam int SLOT_W  = $clog2(N_SLOTS);

    localparam logic [SLOT_W-1:0] SLOT_BS     = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_X      = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_DIG0   = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_DIG1   = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_DIG2   = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_MAIN   = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_BS_END = 3'd6;
    localparam logic [SLOT_W-1:0] SLOT_TERM   = 3'd7;

    typedef enum logic [6:0] {
        PH_NORMAL = 7'b0000001,
        PH_SKIP   = 7'b0000010,
        PH_BS     = 7'b0000100,
        PH_X      = 7'b0001000,
        PH_HEX1   = 7'b0010000,
        PH_HEX2   = 7'b0100000,
        PH_HEX3   = 7'b1000000
    } phase_t;

    // One accepted item's worth of results, in order: a literal flush
    // (backslash, x and held digits), the main unit, a lone backslash and
    // the terminating zero.
    typedef struct packed {
        logic             flush_en;
        logic [2:0]       flush_len;
        logic [2:0][15:0] digits;
        logic             main_en;
        logic [15:0]      main_val;
        logic             bs_end_en;
        logic             term;
    } desc_t;

    function automatic logic is_hex(input logic [15:0] u);
        is_hex = u inside {[16'h0030:16'h0039], [16'h0041:16'h0046], [16'h0061:16'h0066]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [15:0] u);
        if (u inside {[16'h0030:16'h0039]})
        begin
            hex_val = u[3:0];
        end
        else
        begin
            hex_val = 4'(u[3:0] + 4'd9);
        end
    endfunction

    function automatic logic [2:0] pend_len(input phase_t ph);
        case (ph)
            PH_X:    pend_len = 3'd1;
            PH_HEX1: pend_len = 3'd2;
            PH_HEX2: pend_len = 3'd3;
            PH_HEX3: pend_len = 3'd4;
            default: pend_len = 3'd0;
        endcase
    endfunction

endpackage

### rtl/esd_front.sv
module esd_front
    import esd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        end_of_text,
    input  logic        q_full,
    output logic        push,
    output desc_t       push_desc
);

    phase_t           phase_reg, phase_next;
    logic [2:0][15:0] digit_reg, digit_next;
    logic             accept;

    always_comb
    begin
        logic        p_en;
        logic [15:0] p_val;
        phase_t      p_phase;
        phase_t      ph_mid;
        logic        pre;
        logic [1:0]  idx;

        p_en    = 1'b1;
        p_val   = code_unit;
        p_phase = PH_NORMAL;
        if (code_unit == U_CR)
        begin
            p_val   = U_ZERO;
            p_phase = PH_SKIP;
        end
        else if (code_unit == U_LF)
        begin
            p_val = U_ZERO;
        end
        else if (code_unit == U_BSL)
        begin
            p_en    = 1'b0;
            p_phase = PH_BS;
        end

        push_desc  = '0;
        digit_next = digit_reg;
        ph_mid     = phase_reg;
        pre        = 1'b0;
        idx        = 2'(pend_len(phase_reg) - 3'd1);

        case (phase_reg)
            PH_SKIP:
            begin
                ph_mid = PH_NORMAL;
            end
            PH_BS:
            begin
                ph_mid = PH_NORMAL;
                if (code_unit == U_LOW_T)
                begin
                    push_desc.main_en  = 1'b1;
                    push_desc.main_val = U_TAB;
                end
                else if (code_unit == U_LOW_R)
                begin
                    push_desc.main_en  = 1'b1;
                    push_desc.main_val = U_CR;
                end
                else if (code_unit == U_LOW_N)
                begin
                    push_desc.main_en  = 1'b1;
                    push_desc.main_val = U_LF;
                end
                else if (code_unit == U_LOW_X)
                begin
                    ph_mid = PH_X;
                end
                else
                begin
                    pre                = 1'b1;
                    push_desc.main_en  = p_en;
                    push_desc.main_val = p_val;
                    ph_mid             = p_phase;
                end
            end
            PH_X, PH_HEX1, PH_HEX2:
            begin
                if (is_hex(code_unit))
                begin
                    digit_next[idx] = code_unit;
                    ph_mid = (phase_reg == PH_X) ? PH_HEX1 :
                             (phase_reg == PH_HEX1) ? PH_HEX2 : PH_HEX3;
                end
                else
                begin
                    pre                = 1'b1;
                    push_desc.main_en  = p_en;
                    push_desc.main_val = p_val;
                    ph_mid             = p_phase;
                end
            end
            PH_HEX3:
            begin
                if (is_hex(code_unit))
                begin
                    push_desc.main_en  = 1'b1;
                    push_desc.main_val = {hex_val(digit_reg[0]), hex_val(digit_reg[1]),
                                          hex_val(digit_reg[2]), hex_val(code_unit)};
                    ph_mid = PH_NORMAL;
                end
                else
                begin
                    pre                = 1'b1;
                    push_desc.main_en  = p_en;
                    push_desc.main_val = p_val;
                    ph_mid             = p_phase;
                end
            end
            default:
            begin
                push_desc.main_en  = p_en;
                push_desc.main_val = p_val;
                ph_mid             = p_phase;
            end
        endcase

        push_desc.flush_en  = pre;
        push_desc.flush_len = pre ? pend_len(phase_reg) : 3'd0;
        push_desc.digits    = digit_next;
        phase_next          = ph_mid;

        if (end_of_text)
        begin
            if (ph_mid inside {PH_BS, PH_X, PH_HEX1, PH_HEX2, PH_HEX3})
            begin
                if (pre)
                begin
                    push_desc.bs_end_en = 1'b1;
                end
                else
                begin
                    push_desc.flush_en  = 1'b1;
                    push_desc.flush_len = pend_len(ph_mid);
                end
            end
            push_desc.term = 1'b1;
            phase_next     = PH_NORMAL;
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && (push_desc.flush_en || push_desc.main_en ||
                                 push_desc.bs_end_en || push_desc.term);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

### rtl/esd_queue.sv
module esd_queue
    import esd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output desc_t pop_desc,
    output logic  empty
);

    desc_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_desc = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

### rtl/esd_back.sv
module esd_back
    import esd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  desc_t       pop_desc,
    input  logic        q_empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_unit,
    output logic        last
);

    logic [N_SLOTS-1:0] mask_reg, mask_next, mask_after, load_mask;
    desc_t              work_reg;
    logic [SLOT_W-1:0]  sel_idx;
    logic               adv;
    logic               out_valid_reg;
    logic [15:0]        out_unit_reg, sel_val;
    logic               last_reg;

    always_comb
    begin
        sel_idx = '0;
        for (int i = N_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        case (sel_idx)
            SLOT_BS:     sel_val = U_BSL;
            SLOT_X:      sel_val = U_LOW_X;
            SLOT_DIG0:   sel_val = work_reg.digits[0];
            SLOT_DIG1:   sel_val = work_reg.digits[1];
            SLOT_DIG2:   sel_val = work_reg.digits[2];
            SLOT_MAIN:   sel_val = work_reg.main_val;
            SLOT_BS_END: sel_val = U_BSL;
            default:     sel_val = U_ZERO;
        endcase
    end

    always_comb
    begin
        load_mask              = '0;
        load_mask[SLOT_BS]     = pop_desc.flush_en;
        load_mask[SLOT_X]      = pop_desc.flush_en && (pop_desc.flush_len >= 3'd1);
        load_mask[SLOT_DIG0]   = pop_desc.flush_en && (pop_desc.flush_len >= 3'd2);
        load_mask[SLOT_DIG1]   = pop_desc.flush_en && (pop_desc.flush_len >= 3'd3);
        load_mask[SLOT_DIG2]   = pop_desc.flush_en && (pop_desc.flush_len >= 3'd4);
        load_mask[SLOT_MAIN]   = pop_desc.main_en;
        load_mask[SLOT_BS_END] = pop_desc.bs_end_en;
        load_mask[SLOT_TERM]   = pop_desc.term;
    end

    assign adv        = (mask_reg != '0) && (!out_valid_reg || !out_stall);
    assign mask_after = mask_reg & ~(N_SLOTS'(1) << sel_idx);
    assign pop        = !q_empty && ((mask_reg == '0) || (adv && (mask_after == '0)));

    always_comb
    begin
        mask_next = mask_reg;
        if (pop)
        begin
            mask_next = load_mask;
        end
        else if (adv)
        begin
            mask_next = mask_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= pop_desc;
        end
        if (adv)
        begin
            out_unit_reg <= sel_val;
            last_reg     <= (sel_idx == SLOT_TERM);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_unit  = out_unit_reg;
    assign last      = last_reg;

endmodule

### rtl/escape_sequence_decoder_core.sv
// Backslash escape decoder for a stream of 16-bit code units. The front end
// takes one code unit per cycle whenever its four-entry result queue has room,
// and the back end delivers one decoded unit per cycle, while out_stall does
// not hold it, through a registered output. An item may yield up to seven
// results (for a failed hex escape at the end of the text), which the back
// end delivers one after another. Items that yield no result (a held escape
// unit, the unit dropped after a carriage return) push nothing to the queue
// and give no output.
module escape_sequence_decoder_core
    import esd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_unit,
    output logic        last
);

    logic  q_full, q_empty, push, pop;
    desc_t push_desc, pop_desc;

    esd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push        (push),
        .push_desc   (push_desc)
    );

    esd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .empty     (q_empty)
    );

    esd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_desc  (pop_desc),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_unit  (out_unit),
        .last      (last)
    );

endmodule

### verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import esd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int UNIT_TOTAL  = 260;
    localparam int DRAIN_WAIT  = 24;

    typedef struct {
        logic [15:0] unit;
        logic        last;
    } decoded_t;

    class decode_scoreboard;
        phase_t      ph;
        logic [15:0] held [4];
        int          held_n;
        decoded_t    awaited [$];
        int          failures;

        function new();
            ph = PH_NORMAL;
            held_n = 0;
            failures = 0;
            foreach (held[i]) held[i] = U_ZERO;
        endfunction

        function void push(logic [15:0] u, logic l);
            decoded_t d;
            d.unit = u;
            d.last = l;
            awaited.push_back(d);
        endfunction

        function logic is_digit(logic [15:0] u);
            return (u >= 16'h0030 && u <= 16'h0039) || (u >= 16'h0041 && u <= 16'h0046)
                || (u >= 16'h0061 && u <= 16'h0066);
        endfunction

        function logic [3:0] digit_value(logic [15:0] u);
            logic [15:0] v;
            if (u <= 16'h0039)
            begin
                v = u - 16'h0030;
            end
            else if (u <= 16'h0046)
            begin
                v = u - 16'h0041 + 16'd10;
            end
            else
            begin
                v = u - 16'h0061 + 16'd10;
            end
            return v[3:0];
        endfunction

        function void hold(logic [15:0] u);
            held[held_n] = u;
            held_n++;
            case (ph)
                PH_BS:   ph = PH_X;
                PH_X:    ph = PH_HEX1;
                PH_HEX1: ph = PH_HEX2;
                default: ph = PH_HEX3;
            endcase
        endfunction

        function void take_plain(logic [15:0] u);
            if (u == U_CR)
            begin
                push(U_ZERO, 1'b0);
                ph = PH_SKIP;
            end
            else if (u == U_LF)
            begin
                push(U_ZERO, 1'b0);
                ph = PH_NORMAL;
            end
            else if (u == U_BSL)
            begin
                ph = PH_BS;
                held_n = 0;
            end
            else
            begin
                push(u, 1'b0);
                ph = PH_NORMAL;
            end
        endfunction

        function void flush_escape();
            push(U_BSL, 1'b0);
            for (int i = 0; i < held_n; i++)
                push(held[i], 1'b0);
            held_n = 0;
            ph = PH_NORMAL;
        endfunction

        function void note_input(logic [15:0] u, logic eot);
            case (ph)
                PH_SKIP:
                begin
                    ph = PH_NORMAL;
                end
                PH_BS:
                begin
                    if (u == U_LOW_T)
                    begin
                        push(U_TAB, 1'b0);
                        ph = PH_NORMAL;
                    end
                    else if (u == U_LOW_R)
                    begin
                        push(U_CR, 1'b0);
                        ph = PH_NORMAL;
                    end
                    else if (u == U_LOW_N)
                    begin
                        push(U_LF, 1'b0);
                        ph = PH_NORMAL;
                    end
                    else if (u == U_LOW_X)
                    begin
                        held_n = 0;
                        hold(u);
                    end
                    else
                    begin
                        flush_escape();
                        take_plain(u);
                    end
                end
                PH_X, PH_HEX1, PH_HEX2:
                begin
                    if (is_digit(u))
                    begin
                        hold(u);
                    end
                    else
                    begin
                        flush_escape();
                        take_plain(u);
                    end
                end
                PH_HEX3:
                begin
                    if (is_digit(u))
                    begin
                        push({digit_value(held[1]), digit_value(held[2]),
                              digit_value(held[3]), digit_value(u)}, 1'b0);
                        held_n = 0;
                        ph = PH_NORMAL;
                    end
                    else
                    begin
                        flush_escape();
                        take_plain(u);
                    end
                end
                default:
                begin
                    take_plain(u);
                end
            endcase
            if (eot)
            begin
                if (ph inside {PH_BS, PH_X, PH_HEX1, PH_HEX2, PH_HEX3})
                    flush_escape();
                ph = PH_NORMAL;
                held_n = 0;
                push(U_ZERO, 1'b1);
            end
        endfunction

        function void check_result(logic [15:0] u, logic l);
            decoded_t d;
            if (awaited.size() == 0)
            begin
                $error("unexpected transfer: out_unit %h, last %b", u, l);
                failures++;
                return;
            end
            d = awaited.pop_front();
            if (u !== d.unit)
            begin
                $error("out_unit: expected %h, actual %h", d.unit, u);
                failures++;
            end
            if (l !== d.last)
            begin
                $error("last: expected %b, actual %b", d.last, l);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] code_unit = 16'h0000;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] out_unit;
    logic        last;

    decode_scoreboard sb = new();
    int  units_sent = 0;
    int  cycles = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;

    escape_sequence_decoder_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_unit    (out_unit),
        .last        (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(code_unit, end_of_text);
            if (out_valid && !out_stall)
                sb.check_result(out_unit, last);
        end
    end

    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_quiet = !rx_quiet;
            n = rx_quiet ? 0 : $urandom_range(0, 19);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_unit(input logic [15:0] u, input logic eot);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        code_unit <= u;
        end_of_text <= eot;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        units_sent++;
    endtask

    function automatic logic text_ends();
        return $urandom_range(0, 24) == 0;
    endfunction

    function automatic logic [15:0] random_hex_digit();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10)
            return 16'(16'h0030 + k);
        else if (k < 16)
            return 16'(16'h0061 + k - 10);
        return 16'(16'h0041 + k - 16);
    endfunction

    function automatic logic [15:0] random_breaker();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 65535));
            1: return U_CR;
            2: return U_LF;
            3: return U_BSL;
            default: return U_ZERO;
        endcase
    endfunction

    task automatic send_escape_tail(input int digits);
        send_unit(U_BSL, text_ends());
        send_unit(U_LOW_X, text_ends());
        repeat (digits) send_unit(random_hex_digit(), text_ends());
    endtask

    initial
    begin
        int kind;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_unit(16'h0000, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(U_LF, 1'b0);
        send_unit(U_CR, 1'b0);
        send_unit(U_BSL, 1'b0);
        send_unit(U_BSL, 1'b0);
        send_unit(U_LOW_T, 1'b0);
        send_unit(U_BSL, 1'b0);
        send_unit(U_LOW_R, 1'b0);
        send_unit(U_BSL, 1'b0);
        send_unit(U_LOW_N, 1'b0);
        send_unit(U_BSL, 1'b0);
        send_unit(U_LOW_X, 1'b0);
        send_unit(16'h0061, 1'b0);
        send_unit(16'h0046, 1'b0);
        send_unit(16'h0030, 1'b0);
        send_unit(16'h0039, 1'b0);
        send_unit(U_BSL, 1'b0);
        send_unit(U_ZERO, 1'b0);
        send_unit(U_BSL, 1'b0);
        send_unit(U_LOW_X, 1'b0);
        send_unit(16'h0031, 1'b0);
        send_unit(16'h0032, 1'b0);
        send_unit(U_BSL, 1'b0);
        send_unit(U_LOW_X, 1'b0);
        send_unit(16'h0037, 1'b1);
        send_unit(U_CR, 1'b1);

        while (units_sent < UNIT_TOTAL)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                send_unit(16'($urandom_range(0, 65535)), text_ends());
            end
            else if (kind < 40)
            begin
                send_unit(U_CR, text_ends());
                send_unit(16'($urandom_range(0, 65535)), text_ends());
            end
            else if (kind < 48)
            begin
                send_unit(U_LF, text_ends());
            end
            else if (kind < 60)
            begin
                send_unit(U_BSL, text_ends());
                case ($urandom_range(0, 2))
                    0: send_unit(U_LOW_T, text_ends());
                    1: send_unit(U_LOW_R, text_ends());
                    default: send_unit(U_LOW_N, text_ends());
                endcase
            end
            else if (kind < 80)
            begin
                send_escape_tail(4);
            end
            else if (kind < 90)
            begin
                send_escape_tail($urandom_range(0, 3));
                send_unit(random_breaker(), text_ends());
            end
            else
            begin
                send_unit(U_BSL, text_ends());
                send_unit(random_breaker(), text_ends());
            end
        end
        send_unit(16'($urandom_range(0, 65535)), 1'b1);
        in_valid <= 1'b0;
        @(posedge clk);

        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.failures == 0 && sb.awaited.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
